>>> rtl/sbtd_pkg.sv
// Shared types and codes for the strip byte triangle decoder.
package sbtd_pkg;

  localparam int unsigned VIDX_W  = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 8;

  localparam logic [COUNT_W-1:0] NUM_VERTS_RST = 8'd128;

  typedef logic [VIDX_W-1:0]  vidx_t;
  typedef logic [BYTE_W-1:0]  strip_byte_t;
  typedef logic [COUNT_W-1:0] vcount_t;

  // result_kind codes
  localparam logic KIND_FACE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // vertex window of a strip
  typedef struct packed {
    vidx_t oldest;
    vidx_t middle;
    vidx_t newest;
    logic  wind_neg;
  } sbtd_verts_t;

  // outcome of one run step
  typedef struct packed {
    sbtd_verts_t verts;
    vidx_t       vert_a;
    vidx_t       vert_b;
    vidx_t       vert_c;
    logic        bad;
  } sbtd_run_t;

endpackage

>>> rtl/sbtd_if.sv
// Valid/ready channel interfaces for strip bytes, faces and configuration.
interface sbtd_in_if;
  logic                      valid;
  logic                      ready;
  sbtd_pkg::strip_byte_t     strip_byte;
  logic                      mesh_start;

  modport source (output valid, output strip_byte, output mesh_start, input ready);
  modport sink   (input valid, input strip_byte, input mesh_start, output ready);
endinterface

interface sbtd_out_if;
  logic                valid;
  logic                ready;
  logic                result_kind;
  sbtd_pkg::vidx_t     vert_a;
  sbtd_pkg::vidx_t     vert_b;
  sbtd_pkg::vidx_t     vert_c;
  logic                bad_index;

  modport source (output valid, output result_kind, output vert_a, output vert_b,
                  output vert_c, output bad_index, input ready);
  modport sink   (input valid, input result_kind, input vert_a, input vert_b,
                  input vert_c, input bad_index, output ready);
endinterface

interface sbtd_cfg_if;
  logic                valid;
  logic                ready;
  sbtd_pkg::vcount_t   num_verts;

  modport source (output valid, output num_verts, input ready);
  modport sink   (input valid, input num_verts, output ready);
endinterface

>>> rtl/sbtd_run.sv
// Run step of a strip: new index, window shift, winding and face order.
module sbtd_run (
  input  sbtd_pkg::sbtd_verts_t verts,
  input  sbtd_pkg::strip_byte_t strip_byte,
  input  sbtd_pkg::vcount_t     num_verts,
  output sbtd_pkg::sbtd_run_t   run
);
  import sbtd_pkg::*;

  vidx_t       new_idx;
  sbtd_verts_t nv;

  // fan byte: |b|-1 == ~b in the low bits; strip byte: b-1
  assign new_idx = strip_byte[BYTE_W-1] ? ~strip_byte[VIDX_W-1:0]
                                        : strip_byte[VIDX_W-1:0] - vidx_t'(1);

  always_comb begin
    nv = verts;
    if (!strip_byte[BYTE_W-1]) begin
      nv.oldest   = verts.middle;
      nv.wind_neg = ~verts.wind_neg;
    end
    nv.middle = verts.newest;
    nv.newest = new_idx;

    run.verts = nv;
    if (nv.wind_neg) begin
      run.vert_a = nv.newest;
      run.vert_c = nv.oldest;
    end else begin
      run.vert_a = nv.oldest;
      run.vert_c = nv.newest;
    end
    run.vert_b = nv.middle;
    run.bad    = {1'b0, new_idx} >= num_verts;
  end

endmodule

>>> rtl/strip_byte_triangle_decoder_unit.sv
// Top level of the strip byte triangle decoder.
//
// Takes one strip byte per word on in_chan and emits triangle faces (or an
// end-of-mesh marker) on out_chan. A byte is accepted every cycle while the
// output register is empty or being drained, so the sustained rate is one
// byte per clock; a result appears on out_chan the cycle after the byte that
// causes it. The rate is set by the single decode pass between the strip
// state registers and the output register. Three start bytes give the first
// face, each later nonzero byte gives one face, a zero byte closes the strip
// and a negative first byte ends the mesh. After the mesh ends, bytes are
// swallowed until one arrives with mesh_start set. cfg_chan writes the
// vertex count (reset 128); write it only while no byte is in flight.
module strip_byte_triangle_decoder_unit (
  input logic       clk,
  input logic       rst_n,
  sbtd_in_if.sink   in_chan,
  sbtd_out_if.source out_chan,
  sbtd_cfg_if.sink  cfg_chan
);
  import sbtd_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_SECOND,
    PH_THIRD,
    PH_RUN,
    PH_DONE
  } phase_t;

  // strip state
  phase_t      phase_r, phase_nxt;
  sbtd_verts_t verts_r, verts_nxt;
  logic        start_bad_r, start_bad_nxt;
  vcount_t     num_verts_r;

  // output register
  logic        out_valid_r;
  logic        kind_r, kind_nxt;
  vidx_t       va_r, va_nxt;
  vidx_t       vb_r, vb_nxt;
  vidx_t       vc_r, vc_nxt;
  logic        bad_r, bad_nxt;
  logic        emit;

  // effective state after an optional mesh restart
  phase_t      eff_phase;
  sbtd_verts_t eff_verts;
  logic        eff_start_bad;

  logic        acc;
  logic        neg;
  logic        over;
  vidx_t       low_idx;
  sbtd_run_t   run;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign acc           = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign neg     = in_chan.strip_byte[BYTE_W-1];
  assign low_idx = in_chan.strip_byte[VIDX_W-1:0];
  // start bytes are checked as unsigned 8-bit values
  assign over    = neg || (in_chan.strip_byte >= num_verts_r);

  always_comb begin
    if (in_chan.mesh_start) begin
      eff_phase     = PH_START;
      eff_verts     = '0;
      eff_start_bad = 1'b0;
    end else begin
      eff_phase     = phase_r;
      eff_verts     = verts_r;
      eff_start_bad = start_bad_r;
    end
  end

  sbtd_run u_run (
    .verts      (eff_verts),
    .strip_byte (in_chan.strip_byte),
    .num_verts  (num_verts_r),
    .run        (run)
  );

  // decode one byte
  always_comb begin
    phase_nxt     = eff_phase;
    verts_nxt     = eff_verts;
    start_bad_nxt = eff_start_bad;
    emit          = 1'b0;
    kind_nxt      = KIND_FACE;
    va_nxt        = '0;
    vb_nxt        = '0;
    vc_nxt        = '0;
    bad_nxt       = 1'b0;
    case (eff_phase)
      PH_START: begin
        if (neg) begin
          phase_nxt = PH_DONE;
          emit      = 1'b1;
          kind_nxt  = KIND_END;
        end else begin
          verts_nxt.oldest = low_idx;
          start_bad_nxt    = over;
          phase_nxt        = PH_SECOND;
        end
      end
      PH_SECOND: begin
        verts_nxt.middle = low_idx;
        start_bad_nxt    = eff_start_bad || over;
        phase_nxt        = PH_THIRD;
      end
      PH_THIRD: begin
        verts_nxt.newest   = low_idx;
        verts_nxt.wind_neg = 1'b0;
        start_bad_nxt      = eff_start_bad || over;
        phase_nxt          = PH_RUN;
        emit               = 1'b1;
        va_nxt             = eff_verts.oldest;
        vb_nxt             = eff_verts.middle;
        vc_nxt             = low_idx;
        bad_nxt            = eff_start_bad || over;
      end
      PH_RUN: begin
        if (in_chan.strip_byte == '0) begin
          phase_nxt = PH_START;
        end else begin
          verts_nxt = run.verts;
          emit      = 1'b1;
          va_nxt    = run.vert_a;
          vb_nxt    = run.vert_b;
          vc_nxt    = run.vert_c;
          bad_nxt   = run.bad;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      verts_r     <= '0;
      start_bad_r <= 1'b0;
      num_verts_r <= NUM_VERTS_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        num_verts_r <= cfg_chan.num_verts;
      end
      if (acc) begin
        phase_r     <= phase_nxt;
        verts_r     <= verts_nxt;
        start_bad_r <= start_bad_nxt;
      end
      if (acc && emit) begin
        out_valid_r <= 1'b1;
        kind_r      <= kind_nxt;
        va_r        <= va_nxt;
        vb_r        <= vb_nxt;
        vc_r        <= vc_nxt;
        bad_r       <= bad_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = kind_r;
  assign out_chan.vert_a      = va_r;
  assign out_chan.vert_b      = vb_r;
  assign out_chan.vert_c      = vc_r;
  assign out_chan.bad_index   = bad_r;

  // end marker carries no face
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_END) |->
      (va_r == '0 && vb_r == '0 && vc_r == '0 && !bad_r))
    else $error("end marker with nonzero face fields");

  // third start byte always yields a face next cycle
  a_first_face: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && eff_phase == PH_THIRD) |=> (out_valid_r && kind_r == KIND_FACE))
    else $error("first face not emitted");

  // ended mesh stays ended until a restart
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == PH_DONE && !in_chan.mesh_start) |=> (phase_r == PH_DONE))
    else $error("left mesh end without mesh_start");

  // zero byte in a run closes the strip without a result
  a_strip_close: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && eff_phase == PH_RUN && in_chan.strip_byte == '0) |=>
      (phase_r == PH_START && !(out_valid_r && !$past(out_valid_r && !out_chan.ready))))
    else $error("strip close misbehaved");

endmodule

>>> test/strip_byte_triangle_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Strip byte triangle decoder testbench: directed and random streams checked against a predictor.
module strip_byte_triangle_decoder_unit_tb;
  import sbtd_pkg::*;

  // Decoder phase as the predictor tracks it.
  typedef enum logic [2:0] {
    ST_OPEN,     // waiting for the first index byte of a strip
    ST_SECOND,
    ST_THIRD,
    ST_RUN,      // strip/fan steps until a zero byte
    ST_ENDED     // mesh closed, bytes swallowed until mesh_start
  } decode_phase_e;

  // Receiver stall patterns.
  localparam int RX_ALWAYS  = 0;
  localparam int RX_COIN    = 1;
  localparam int RX_MOSTLY  = 2;
  localparam int RX_SPARSE  = 3;
  localparam int RX_PATTERN = 4;

  localparam int NUM_PHASES     = 7;
  localparam int WORDS_PER_PH   = 155;
  localparam int LONG_HOLD_CYC  = 300;
  localparam int SETTLE_CYC     = 4;

  typedef struct packed {
    logic  kind;
    vidx_t a;
    vidx_t b;
    vidx_t c;
    logic  bad;
  } face_t;

  typedef struct packed {
    strip_byte_t strip_byte;
    logic        mesh_start;
  } stim_word_t;

  // Predicts faces from accepted bytes and checks what comes out.
  class face_scoreboard;
    vcount_t       vcount;
    decode_phase_e phase;
    vidx_t         oldest;
    vidx_t         middle;
    vidx_t         newest;
    logic          wind_neg;
    logic          start_bad;
    face_t         pending_faces[$];
    int            errors;

    function void restart();
      phase     = ST_OPEN;
      oldest    = '0;
      middle    = '0;
      newest    = '0;
      wind_neg  = 1'b0;
      start_bad = 1'b0;
    endfunction

    function void push_face(logic kind, vidx_t a, vidx_t b, vidx_t c, logic bad);
      face_t f;
      f.kind = kind;
      f.a    = a;
      f.b    = b;
      f.c    = c;
      f.bad  = bad;
      pending_faces = {pending_faces, f};
    endfunction

    // One accepted strip byte.
    function void note_byte(strip_byte_t sbyte, logic mstart);
      logic  neg;
      logic  over;
      vidx_t nv;
      neg  = sbyte[7];
      over = neg || (sbyte >= vcount);
      if (mstart) restart();
      case (phase)
        ST_OPEN: begin
          if (neg) begin
            phase = ST_ENDED;
            push_face(KIND_END, '0, '0, '0, 1'b0);
          end else begin
            oldest    = sbyte[6:0];
            start_bad = over;
            phase     = ST_SECOND;
          end
        end
        ST_SECOND: begin
          middle    = sbyte[6:0];
          start_bad = start_bad || over;
          phase     = ST_THIRD;
        end
        ST_THIRD: begin
          newest    = sbyte[6:0];
          start_bad = start_bad || over;
          wind_neg  = 1'b0;
          phase     = ST_RUN;
          push_face(KIND_FACE, oldest, middle, newest, start_bad);
        end
        ST_RUN: begin
          if (sbyte == '0) begin
            phase = ST_OPEN;
          end else begin
            if (neg) begin
              nv = ~sbyte[6:0];          // |b|-1, and -128 lands on 127
            end else begin
              nv       = sbyte[6:0] - 7'd1;
              oldest   = middle;
              wind_neg = ~wind_neg;
            end
            middle = newest;
            newest = nv;
            if (wind_neg)
              push_face(KIND_FACE, newest, middle, oldest, {1'b0, nv} >= vcount);
            else
              push_face(KIND_FACE, oldest, middle, newest, {1'b0, nv} >= vcount);
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_face(face_t got);
      face_t want;
      if (pending_faces.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d a=%0d b=%0d c=%0d bad=%0d",
                                  got.kind, got.a, got.b, got.c, got.bad));
        return;
      end
      want = pending_faces.pop_front();
      compare_field("result_kind", int'(got.kind), int'(want.kind));
      compare_field("vert_a", int'(got.a), int'(want.a));
      compare_field("vert_b", int'(got.b), int'(want.b));
      compare_field("vert_c", int'(got.c), int'(want.c));
      compare_field("bad_index", int'(got.bad), int'(want.bad));
    endtask
  endclass

  logic clk;
  logic rst_n;

  sbtd_in_if  in_if ();
  sbtd_out_if out_if ();
  sbtd_cfg_if cfg_if ();

  strip_byte_triangle_decoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  face_scoreboard sb;
  stim_word_t     stim_q[$];
  int             rx_mode;
  int             gap_max;
  bit             long_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Monitor: both channels sampled at the edge, before the design updates.
  always @(posedge clk) begin : monitor
    face_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_byte(in_if.strip_byte, in_if.mesh_start);
      if (out_if.valid && out_if.ready) begin
        got.kind = out_if.result_kind;
        got.a    = out_if.vert_a;
        got.b    = out_if.vert_b;
        got.c    = out_if.vert_c;
        got.bad  = out_if.bad_index;
        sb.check_face(got);
      end
    end
  end

  // Receiver: stall pattern per mode, plus a long hold-off on request that
  // lets the output register fill and back up the input.
  initial begin : receiver
    int hold_left;
    int tick;
    hold_left = 0;
    tick      = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_if.ready <= 1'b1;
          RX_COIN:    out_if.ready <= ($urandom_range(0, 1) != 0);
          RX_MOSTLY:  out_if.ready <= ($urandom_range(0, 7) != 0);
          RX_SPARSE:  out_if.ready <= ($urandom_range(0, 3) == 0);
          default:    out_if.ready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  task automatic push_word(input strip_byte_t b, input logic ms);
    stim_word_t w;
    w.strip_byte = b;
    w.mesh_start = ms;
    stim_q = {stim_q, w};
  endtask

  // Start index byte; later start bytes are now and then negative.
  function automatic strip_byte_t start_index(input bit allow_neg);
    if (allow_neg && $urandom_range(0, 15) == 0)
      return strip_byte_t'($urandom_range(128, 255));
    return strip_byte_t'($urandom_range(0, 127));
  endfunction

  // Well-formed mesh: a few strips, each closed by zero, then the end marker.
  task automatic gen_mesh();
    int strips;
    int run_len;
    int tail;
    strips = $urandom_range(1, 4);
    for (int s = 0; s < strips; s++) begin
      push_word(start_index(1'b0), s == 0);
      push_word(start_index(1'b1), 1'b0);
      push_word(start_index(1'b1), 1'b0);
      run_len = $urandom_range(0, 12);
      for (int k = 0; k < run_len; k++)
        push_word(strip_byte_t'($urandom_range(1, 255)), 1'b0);
      push_word(8'h00, 1'b0);
    end
    push_word(strip_byte_t'($urandom_range(128, 255)), 1'b0);
    // bytes after mesh end should be swallowed
    tail = $urandom_range(0, 3);
    for (int k = 0; k < tail; k++) push_word(strip_byte_t'($urandom_range(0, 255)), 1'b0);
  endtask

  // Mostly meshes, some raw noise and meshes cut short by a new mesh_start.
  task automatic gen_random(input int target);
    int sel;
    int n;
    while (stim_q.size() < target) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          push_word(strip_byte_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (sel == 1) begin
        push_word(start_index(1'b0), 1'b1);
        n = $urandom_range(0, 4);
        for (int k = 0; k < n; k++)
          push_word(strip_byte_t'($urandom_range(1, 255)), 1'b0);
      end else begin
        gen_mesh();
      end
    end
  endtask

  // Sender: bursts with random gaps; optional pause until all faces are out.
  task automatic play_stimulus(input int pause_at);
    stim_word_t w;
    int idx;
    int burst_left;
    int gap;
    idx        = 0;
    burst_left = $urandom_range(1, 24);
    while (stim_q.size() != 0) begin
      w = stim_q.pop_front();
      in_if.valid      <= 1'b1;
      in_if.strip_byte <= w.strip_byte;
      in_if.mesh_start <= w.mesh_start;
      @(posedge clk);
      while (!in_if.ready) @(posedge clk);
      idx++;
      burst_left--;
      if (idx == pause_at) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_faces.size() != 0) @(posedge clk);
      end else if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        if (gap_max > 0) begin
          gap = $urandom_range(1, gap_max);
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_if.valid <= 1'b0;
  endtask

  // Wait until every face is out, then let a word with no result settle.
  task automatic idle_wait();
    @(posedge clk);
    while (sb.pending_faces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_num_verts(input vcount_t v);
    cfg_if.valid     <= 1'b1;
    cfg_if.num_verts <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.vcount = v;
  endtask

  initial begin : main
    vcount_t vc;
    sb = new();
    sb.restart();
    sb.vcount     = NUM_VERTS_RST;
    sb.errors     = 0;
    rx_mode       = RX_ALWAYS;
    gap_max       = 0;
    long_hold_req = 1'b0;

    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.strip_byte <= '0;
    in_if.mesh_start <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.num_verts <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed stream at the reset vertex count.
    push_word(8'h00, 1'b1);  // index extremes in the first face
    push_word(8'h7F, 1'b0);
    push_word(8'h01, 1'b0);
    push_word(8'h01, 1'b0);  // strip step, winding flips
    push_word(8'h80, 1'b0);  // fan step, -128 wraps to 127
    push_word(8'hFF, 1'b0);  // fan step, index 0
    push_word(8'h7F, 1'b0);  // strip step, index 126
    push_word(8'h00, 1'b0);  // close strip
    push_word(8'h05, 1'b0);  // next strip restarts with positive winding
    push_word(8'h85, 1'b0);  // negative second start byte flags the face
    push_word(8'h10, 1'b0);
    push_word(8'h02, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h80, 1'b0);  // negative first byte: end of mesh
    push_word(8'h33, 1'b0);  // swallowed after mesh end
    push_word(8'h00, 1'b0);
    push_word(8'h90, 1'b0);
    push_word(8'hC0, 1'b1);  // mesh_start with negative byte: immediate end
    push_word(8'h01, 1'b1);
    push_word(8'h02, 1'b0);
    push_word(8'h03, 1'b1);  // mesh_start mid-strip resets the decoder
    push_word(8'h04, 1'b0);
    push_word(8'hFE, 1'b0);  // negative third start byte
    push_word(8'h06, 1'b0);
    push_word(8'h80, 1'b0);  // negative run byte ends nothing in run
    rx_mode = RX_COIN;
    gap_max = 3;
    play_stimulus(-1);
    idle_wait();

    // Random phases, each at its own vertex count and idling mix.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       vc = 8'd0;
        1:       vc = 8'd1;
        2:       vc = 8'd128;
        3:       vc = 8'd127;
        5:       vc = 8'd64;
        default: vc = vcount_t'($urandom_range(0, 128));
      endcase
      write_num_verts(vc);
      gen_random(WORDS_PER_PH);
      case (p)
        0: begin
          rx_mode = RX_ALWAYS;  // full rate, no idling anywhere
          gap_max = 0;
        end
        2: begin
          rx_mode       = RX_MOSTLY;
          gap_max       = 0;
          long_hold_req = 1'b1;  // sender keeps offering into a stalled block
        end
        default: begin
          rx_mode = p % 5;
          gap_max = (p % 2) ? 6 : 2;
        end
      endcase
      play_stimulus((p == 3) ? 80 : -1);
      idle_wait();
    end

    repeat (10) @(posedge clk);
    if (sb.pending_faces.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived",
                                   sb.pending_faces.size()));
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> strip_byte_triangle_decoder_unit.f
rtl/sbtd_pkg.sv
rtl/sbtd_if.sv
rtl/sbtd_run.sv
rtl/strip_byte_triangle_decoder_unit.sv
test/strip_byte_triangle_decoder_unit_tb.sv
